// ----- rtl/apcbr_pkg.sv -----
// Shared types and constants of the ATA PIO cached byte reader.
package apcbr_pkg;

  localparam int DRIVES_DEF    = 4;
  localparam int SECTOR_BYTES  = 512;
  localparam int SECTOR_WORDS  = SECTOR_BYTES / 2;
  localparam int WORD_IDX_W    = $clog2(SECTOR_WORDS);
  localparam int OFF_W         = $clog2(SECTOR_BYTES);
  localparam int SECT_W        = 48;
  localparam int ADDR_IN_W     = 57;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 48;
  localparam int STEP_W        = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAP = 3'd4;
  localparam logic [7:0]           DRIVE_MAP_RST = 8'hAC;

  // Taskfile register offsets.
  localparam logic [2:0] TF_DATA    = 3'd0;
  localparam logic [2:0] TF_COUNT   = 3'd2;
  localparam logic [2:0] TF_LBA_LO  = 3'd3;
  localparam logic [2:0] TF_LBA_MID = 3'd4;
  localparam logic [2:0] TF_LBA_HI  = 3'd5;
  localparam logic [2:0] TF_DEVICE  = 3'd6;
  localparam logic [2:0] TF_CMD     = 3'd7;

  localparam logic [SECT_W-1:0] LBA28_MAX = 48'h0000_0FFF_FFFF;
  localparam logic [7:0] DEV_LBA28_MASTER = 8'hE0;
  localparam logic [7:0] DEV_LBA28_SLAVE  = 8'hF0;
  localparam logic [7:0] DEV_LBA48_MASTER = 8'h40;
  localparam logic [7:0] DEV_LBA48_SLAVE  = 8'h50;
  localparam logic [7:0] CMD_READ_PIO     = 8'h20;
  localparam logic [7:0] CMD_READ_PIO_EXT = 8'h24;
  localparam int STS_BSY_BIT = 7;
  localparam int STS_ERR_BIT = 0;

  typedef enum logic [2:0] {
    KIND_WRITE = 3'd0,
    KIND_READ  = 3'd1,
    KIND_BYTE  = 3'd2,
    KIND_EOF   = 3'd3,
    KIND_FAIL  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_STATUS = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  // Work handed from the request decoder to the result sequencer.
  typedef struct packed {
    logic              single;
    kind_t             kind;
    logic              chan;
    logic [2:0]        reg_off;
    logic              word;
    logic              from_mem;
    logic              fwd;
    logic [7:0]        fwd_byte;
    logic              byte_hi;
    logic              lba48;
    logic              slave;
    logic [SECT_W-1:0] sect;
  } job_t;

  typedef struct packed {
    kind_t      kind;
    logic       chan;
    logic [2:0] reg_off;
    logic       word;
    logic [7:0] bus_data;
    logic [7:0] byte_val;
    logic       last;
  } res_t;

endpackage

// ----- rtl/apcbr_if.sv -----
// Channel interfaces: request/response input and result output.
interface apcbr_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [1:0]  drive;
  logic [56:0] byte_address;
  logic [15:0] response_data;

  modport source (output valid, output operation, output drive, output byte_address,
                  output response_data, input ready);
  modport sink (input valid, input operation, input drive, input byte_address,
                input response_data, output ready);
endinterface

interface apcbr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic       channel;
  logic [2:0] register_offset;
  logic       word_access;
  logic [7:0] bus_data;
  logic [7:0] byte_value;
  logic       last;

  modport source (output valid, output result_kind, output channel, output register_offset,
                  output word_access, output bus_data, output byte_value, output last,
                  input ready);
  modport sink (input valid, input result_kind, input channel, input register_offset,
                input word_access, input bus_data, input byte_value, input last,
                output ready);
endinterface

// ----- rtl/ata_pio_cached_byte_reader_core.sv -----
// ATA PIO cached byte reader: top level with the sector cache memory and request decoder.
// A cache hit, EOF or failure passes through the sequencer's job register and then its output
// register; one such item is taken every cycle while results are drained.
// A sector fetch's command job emits 7 (LBA28) or 11 (LBA48) results, one per cycle unless the output stalls.
// Each device data word is one write into the 16-bit wide cache memory.
// Synchronous reset clears phase, pending state and valid bits and loads config defaults; no clearing pass.
module ata_pio_cached_byte_reader_core
  import apcbr_pkg::*;
#(
  parameter int DRIVES = DRIVES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  apcbr_in_if.sink              in_chan,
  apcbr_out_if.source           out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DRV_W   = (DRIVES > 1) ? $clog2(DRIVES) : 1;
  localparam int DEPTH   = DRIVES * SECTOR_WORDS;
  localparam int MADDR_W = $clog2(DEPTH);
  localparam logic [2:0] DRIVES_N = 3'(DRIVES);

  // Configuration.
  logic [SECT_W-1:0] sectors_r [4];
  logic [7:0]        map_r;

  // Engine state.
  phase_t                phase_r, phase_nxt;
  logic [1:0]            pend_drive_r, pend_drive_nxt;
  logic [SECT_W-1:0]     pend_sect_r, pend_sect_nxt;
  logic [OFF_W-1:0]      pend_off_r, pend_off_nxt;
  logic [WORD_IDX_W-1:0] word_idx_r, word_idx_nxt;
  logic                  valid_r [DRIVES];
  logic [SECT_W-1:0]     tag_r [DRIVES];

  logic [15:0]           mem [DEPTH];
  logic [15:0]           rdata_r;

  logic                  accept;
  logic                  job_rdy;
  logic                  job_vld;
  job_t                  job;
  logic                  mem_we, mem_re;
  logic [MADDR_W-1:0]    mem_waddr, mem_raddr;
  logic                  valid_clr, valid_set;
  logic [SECT_W-1:0]     in_sect;
  logic [OFF_W-1:0]      in_off;
  logic [DRV_W-1:0]      in_di, pend_di;
  logic [7:0]            status;
  res_t                  res;

  assign in_chan.ready = job_rdy;
  assign accept  = in_chan.valid && job_rdy;
  assign in_sect = in_chan.byte_address[ADDR_IN_W-1:OFF_W];
  assign in_off  = in_chan.byte_address[OFF_W-1:0];
  assign in_di   = in_chan.drive[DRV_W-1:0];
  assign pend_di = pend_drive_r[DRV_W-1:0];
  assign status  = in_chan.response_data[7:0];

  always_comb begin
    phase_nxt      = phase_r;
    pend_drive_nxt = pend_drive_r;
    pend_sect_nxt  = pend_sect_r;
    pend_off_nxt   = pend_off_r;
    word_idx_nxt   = word_idx_r;
    job            = '0;
    job_vld        = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = MADDR_W'({pend_drive_r, word_idx_r});
    mem_raddr      = MADDR_W'({in_chan.drive, in_off[OFF_W-1:1]});
    valid_clr      = 1'b0;
    valid_set      = 1'b0;
    if (accept) begin
      job.single = 1'b1;
      if (!in_chan.operation) begin
        job_vld = 1'b1;
        if (phase_r != PH_IDLE) begin
          job.kind = KIND_FAIL;
        end else if ({1'b0, in_chan.drive} >= DRIVES_N) begin
          job.kind = KIND_EOF;
        end else if (valid_r[in_di] && tag_r[in_di] == in_sect) begin
          job.kind     = KIND_BYTE;
          job.from_mem = 1'b1;
          job.byte_hi  = in_off[0];
          mem_re       = 1'b1;
        end else if (in_sect >= sectors_r[in_chan.drive]) begin
          job.kind = KIND_EOF;
        end else begin
          job.single     = 1'b0;
          job.kind       = KIND_WRITE;
          job.chan       = map_r[{1'b0, in_chan.drive}];
          job.slave      = map_r[{1'b1, in_chan.drive}];
          job.lba48      = in_sect > LBA28_MAX;
          job.sect       = in_sect;
          pend_drive_nxt = in_chan.drive;
          pend_sect_nxt  = in_sect;
          pend_off_nxt   = in_off;
          word_idx_nxt   = '0;
          phase_nxt      = PH_STATUS;
        end
      end else begin
        case (phase_r)
          PH_STATUS: begin
            job_vld  = 1'b1;
            job.chan = map_r[{1'b0, pend_drive_r}];
            if (status[STS_ERR_BIT]) begin
              job.kind  = KIND_FAIL;
              job.chan  = 1'b0;
              phase_nxt = PH_IDLE;
            end else if (status[STS_BSY_BIT]) begin
              job.kind    = KIND_READ;
              job.reg_off = TF_CMD;
            end else begin
              job.kind     = KIND_READ;
              job.reg_off  = TF_DATA;
              job.word     = 1'b1;
              phase_nxt    = PH_DATA;
              word_idx_nxt = '0;
              valid_clr    = 1'b1;
            end
          end
          PH_DATA: begin
            job_vld = 1'b1;
            mem_we  = 1'b1;
            if (&word_idx_r) begin
              job.kind     = KIND_BYTE;
              job.from_mem = 1'b1;
              job.byte_hi  = pend_off_r[0];
              job.fwd      = word_idx_r == pend_off_r[OFF_W-1:1];
              job.fwd_byte = pend_off_r[0] ? in_chan.response_data[15:8]
                                           : in_chan.response_data[7:0];
              mem_re       = 1'b1;
              mem_raddr    = MADDR_W'({pend_drive_r, pend_off_r[OFF_W-1:1]});
              valid_set    = 1'b1;
              phase_nxt    = PH_IDLE;
              word_idx_nxt = '0;
            end else begin
              job.kind     = KIND_READ;
              job.chan     = map_r[{1'b0, pend_drive_r}];
              job.reg_off  = TF_DATA;
              job.word     = 1'b1;
              word_idx_nxt = word_idx_r + WORD_IDX_W'(1);
            end
          end
          default: begin
            // A device response with no transfer pending produces nothing.
            job_vld = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      pend_drive_r <= '0;
      pend_sect_r  <= '0;
      pend_off_r   <= '0;
      word_idx_r   <= '0;
      map_r        <= DRIVE_MAP_RST;
      for (int i = 0; i < 4; i++) begin
        sectors_r[i] <= '0;
      end
      for (int i = 0; i < DRIVES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      phase_r      <= phase_nxt;
      pend_drive_r <= pend_drive_nxt;
      pend_sect_r  <= pend_sect_nxt;
      pend_off_r   <= pend_off_nxt;
      word_idx_r   <= word_idx_nxt;
      if (valid_clr) begin
        valid_r[pend_di] <= 1'b0;
      end else if (valid_set) begin
        valid_r[pend_di] <= 1'b1;
      end
      if (cfg_we) begin
        if (cfg_index < CFG_DRIVE_MAP) begin
          sectors_r[cfg_index[1:0]] <= cfg_wdata;
        end else if (cfg_index == CFG_DRIVE_MAP) begin
          map_r <= cfg_wdata[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (valid_set) begin
      tag_r[pend_di] <= pend_sect_r;
    end
  end

  // Sector cache, one 16-bit word per entry, little-endian byte order.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_chan.response_data;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  apcbr_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_vld   (job_vld),
    .job_in    (job),
    .mem_rdata (rdata_r),
    .job_rdy   (job_rdy),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (res)
  );

  assign out_chan.result_kind     = res.kind;
  assign out_chan.channel         = res.chan;
  assign out_chan.register_offset = res.reg_off;
  assign out_chan.word_access     = res.word;
  assign out_chan.bus_data        = res.bus_data;
  assign out_chan.byte_value      = res.byte_val;
  assign out_chan.last            = res.last;

endmodule

// ----- rtl/apcbr_emit.sv -----
// Result sequencer: expands one job into its results through an output register.
module apcbr_emit
  import apcbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_vld,
  input  job_t        job_in,
  input  logic [15:0] mem_rdata,
  output logic        job_rdy,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res
);

  typedef struct packed {
    logic       is_read;
    logic [2:0] reg_off;
    logic [7:0] data;
  } step_t;

  // Taskfile sequence of a sector read; the status read closes it.
  function automatic step_t seq_step(logic lba48, logic slave, logic [SECT_W-1:0] sect,
                                     logic [STEP_W-1:0] idx);
    step_t s;
    s = '0;
    if (!lba48) begin
      case (idx)
        4'd0: begin
          s.reg_off = TF_DEVICE;
          s.data = (slave ? DEV_LBA28_SLAVE : DEV_LBA28_MASTER) | {4'h0, sect[27:24]};
        end
        4'd1: begin s.reg_off = TF_COUNT;   s.data = 8'd1;         end
        4'd2: begin s.reg_off = TF_LBA_LO;  s.data = sect[7:0];    end
        4'd3: begin s.reg_off = TF_LBA_MID; s.data = sect[15:8];   end
        4'd4: begin s.reg_off = TF_LBA_HI;  s.data = sect[23:16];  end
        4'd5: begin s.reg_off = TF_CMD;     s.data = CMD_READ_PIO; end
        default: begin s.is_read = 1'b1; s.reg_off = TF_CMD; end
      endcase
    end else begin
      case (idx)
        4'd0: begin
          s.reg_off = TF_DEVICE;
          s.data = slave ? DEV_LBA48_SLAVE : DEV_LBA48_MASTER;
        end
        4'd1: begin s.reg_off = TF_COUNT;   s.data = 8'd0;             end
        4'd2: begin s.reg_off = TF_LBA_LO;  s.data = sect[31:24];      end
        4'd3: begin s.reg_off = TF_LBA_MID; s.data = sect[39:32];      end
        4'd4: begin s.reg_off = TF_LBA_HI;  s.data = sect[47:40];      end
        4'd5: begin s.reg_off = TF_COUNT;   s.data = 8'd1;             end
        4'd6: begin s.reg_off = TF_LBA_LO;  s.data = sect[7:0];        end
        4'd7: begin s.reg_off = TF_LBA_MID; s.data = sect[15:8];       end
        4'd8: begin s.reg_off = TF_LBA_HI;  s.data = sect[23:16];      end
        4'd9: begin s.reg_off = TF_CMD;     s.data = CMD_READ_PIO_EXT; end
        default: begin s.is_read = 1'b1; s.reg_off = TF_CMD; end
      endcase
    end
    return s;
  endfunction

  logic              busy_r;
  job_t              job_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  res_t              out_res_r;

  step_t st;
  res_t  res;
  logic  out_free;
  logic  fire;
  logic  done;

  always_comb begin
    st  = seq_step(job_r.lba48, job_r.slave, job_r.sect, step_r);
    res = '0;
    if (job_r.single) begin
      res.kind    = job_r.kind;
      res.chan    = job_r.chan;
      res.reg_off = job_r.reg_off;
      res.word    = job_r.word;
      res.last    = 1'b1;
      if (job_r.from_mem) begin
        // The final data word is written while the byte is read, so it is forwarded.
        if (job_r.fwd) begin
          res.byte_val = job_r.fwd_byte;
        end else begin
          res.byte_val = job_r.byte_hi ? mem_rdata[15:8] : mem_rdata[7:0];
        end
      end
    end else begin
      res.kind     = st.is_read ? KIND_READ : KIND_WRITE;
      res.chan     = job_r.chan;
      res.reg_off  = st.reg_off;
      res.bus_data = st.data;
      res.last     = st.is_read;
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign fire      = busy_r && out_free;
  assign done      = fire && res.last;
  assign job_rdy   = !busy_r || done;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_vld && job_rdy) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (done) begin
        busy_r <= 1'b0;
      end else if (fire) begin
        step_r <= step_r + STEP_W'(1);
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_vld && job_rdy) begin
      job_r <= job_in;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

endmodule

// ----- rtl/apcbr_checker.sv -----
// Port-level checker for the cached byte reader, bound to the top level.
module apcbr_checker
  import apcbr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic [2:0] out_kind,
  input logic [2:0] out_reg,
  input logic       out_word,
  input logic [7:0] out_data,
  input logic       out_last
);

  // Byte, EOF and failure results always stand alone.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_BYTE || out_kind == KIND_EOF || out_kind == KIND_FAIL)
    |-> out_last)
    else $error("single result without last");

  // A taskfile write is never the final result of a transaction; a bus read always is.
  a_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_WRITE |-> !out_last)
    else $error("bus write marked last");

  a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_READ |-> out_last && out_data == 8'd0)
    else $error("bus read not last or with data");

  a_word_data_port: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word |-> out_kind == KIND_READ && out_reg == TF_DATA)
    else $error("word access outside data port read");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ata_pio_cached_byte_reader_core apcbr_checker u_apcbr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_kind  (out_chan.result_kind),
  .out_reg   (out_chan.register_offset),
  .out_word  (out_chan.word_access),
  .out_data  (out_chan.bus_data),
  .out_last  (out_chan.last)
);
